// ===== hdl/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Shared widths, status codes and sequencer types for the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned CountW   = SlotW + 1;
  localparam int unsigned KeyW     = 32;

  typedef logic [SlotW-1:0]  slot_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [KeyW-1:0]   key_t;

  // Status codes of a result item.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusEmpty    = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  // Operation kinds of an input item.
  localparam logic KindUpdate = 1'b0;
  localparam logic KindPop    = 1'b1;

  // Configuration register indexes.
  localparam logic CfgEntryCount = 1'b0;
  localparam logic CfgInitialKey = 1'b1;

  // Compare result handed from the compare unit to the sequencer.
  typedef struct packed {
    logic up_swap;    // parent key strictly above current key
    logic go_right;   // right child wins the move down
    logic go_left;    // left child wins the move down
  } cmp_t;

endpackage

// ===== hdl/imh_cmp.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap compare unit
// Shared key comparator used for every step of the sift up and sift down.
// ----------------------------------------------------------------------------
module imh_cmp (
  input  imh_pkg::key_t   cur_key_i,
  input  imh_pkg::key_t   par_key_i,
  input  imh_pkg::key_t   lft_key_i,
  input  imh_pkg::key_t   rgt_key_i,
  input  logic            lft_ok_i,
  input  logic            rgt_ok_i,
  output imh_pkg::cmp_t   cmp_o
);
  import imh_pkg::*;

  logic r_lt_l, r_lt_c, l_lt_c;

  // Strict comparisons keep equal keys in place.
  always_comb begin
    r_lt_l = rgt_key_i < lft_key_i;
    r_lt_c = rgt_key_i < cur_key_i;
    l_lt_c = lft_key_i < cur_key_i;
    cmp_o.up_swap  = par_key_i > cur_key_i;
    cmp_o.go_right = rgt_ok_i && r_lt_l && r_lt_c;
    cmp_o.go_left  = !cmp_o.go_right && lft_ok_i && l_lt_c;
  end

endmodule

// ===== hdl/indexed_min_heap_decrease_key_top.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap top level
// Heap of identifiers keyed by 32-bit keys with update-key and pop-minimum.
// ----------------------------------------------------------------------------
// Sequencing: an update looks up the item's slot, then moves the entry up and
//   then down one level per step; a pop takes the root, refills it from the
//   last slot and moves down; an error result goes straight to the output.
//   One item is in work at a time. The next item is taken in the idle state
//   after a registered result; a held result stalls only the next result.
// Reset, and any configuration write, runs a clearing pass over every slot
//   that reloads identity maps and the initial key; no item is taken then.
module indexed_min_heap_decrease_key_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // item_id[7:0], new_key[39:8]
  input  logic        s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o   // status[1:0], min_key[33:2],
                                       // min_id[41:34], remaining[50:42]
);
  import imh_pkg::*;

  typedef enum logic [8:0] {
    StClear = 9'b000000001,
    StIdle  = 9'b000000010,
    StLook  = 9'b000000100,
    StRead  = 9'b000001000,
    StCmp   = 9'b000010000,
    StSwapA = 9'b000100000,
    StPopA  = 9'b001000000,
    StPopB  = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Heap memories.
  key_t  key_mem [Capacity];
  slot_t id_mem  [Capacity];
  slot_t slot_mem[Capacity];

  count_t  entry_count_q;
  key_t    initial_key_q;
  count_t  count_q;
  slot_t   clr_q;
  logic    clr_last_q;
  slot_t   cur_q;
  key_t    cur_key_q;
  slot_t   cur_id_q;
  logic    kind_q;
  logic    down_q;
  key_t    new_key_q;
  slot_t   qid_q;
  key_t    par_key_q, lft_key_q, rgt_key_q;
  slot_t   par_id_q, lft_id_q, rgt_id_q;
  logic    out_valid_q;
  logic [50:0] out_data_q;
  logic [1:0] st_q;
  key_t    mkey_q;
  slot_t   mid_q;
  cmp_t    cmp;

  logic in_acc, cfg_acc, out_acc, out_load;
  key_t  rd_ka, rd_kb;
  slot_t rd_ia, rd_ib, rd_sl;
  slot_t rd_addr_a, rd_addr_b;

  // Child and parent slot numbers of the current slot, and the last slot.
  logic [SlotW+1:0] lft_s, rgt_s;
  slot_t            par_s;
  slot_t            last_s;
  assign lft_s  = {1'b0, cur_q, 1'b1};
  assign rgt_s  = {1'b0, cur_q, 1'b0} + (SlotW+2)'(2);
  assign par_s  = (cur_q - slot_t'(1)) >> 1;
  assign last_s = count_q[SlotW-1:0] - slot_t'(1);

  imh_cmp u_cmp (
    .cur_key_i(cur_key_q),
    .par_key_i(par_key_q),
    .lft_key_i(lft_key_q),
    .rgt_key_i(rgt_key_q),
    .lft_ok_i (lft_s < (SlotW+2)'(count_q)),
    .rgt_ok_i (rgt_s < (SlotW+2)'(count_q)),
    .cmp_o    (cmp)
  );

  assign cfg_ready_o     = (state_q == StIdle) || (state_q == StClear);
  assign cfg_acc         = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready_o = (state_q == StIdle) && !cfg_valid_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign out_load        = (state_q == StOut) && (!out_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_data_q};

  // Read addresses: root and last slot for a pop, else parent or children.
  assign rd_addr_a = (state_q == StPopA) ? '0
                                         : (down_q ? lft_s[SlotW-1:0] : par_s);
  assign rd_addr_b = (state_q == StPopA) ? last_s : rgt_s[SlotW-1:0];

  // Memory reads: two addresses for keys and identifiers, one for slots.
  always_ff @(posedge clk_i) begin
    rd_sl <= slot_mem[s_axis_tdata_i[SlotW-1:0]];
    rd_ka <= key_mem[rd_addr_a];
    rd_ia <= id_mem[rd_addr_a];
    rd_kb <= key_mem[rd_addr_b];
    rd_ib <= id_mem[rd_addr_b];
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: state_d = clr_last_q ? StIdle : StClear;
      StIdle:  if (cfg_acc) state_d = StClear;
               else if (in_acc) state_d = StLook;
      StLook:  state_d = StRead;
      StRead:  state_d = StCmp;
      StCmp:   state_d = StSwapA;
      StSwapA: state_d = StOut;
      StPopA:  state_d = StPopB;
      StPopB:  state_d = StRead;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control and data registers of the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StClear;
      entry_count_q <= count_t'(Capacity);
      initial_key_q <= '1;
      count_q       <= count_t'(Capacity);
      clr_q         <= '0;
      clr_last_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      cur_q         <= '0;
      cur_key_q     <= '0;
      cur_id_q      <= '0;
      kind_q        <= 1'b0;
      down_q        <= 1'b0;
      new_key_q     <= '0;
      qid_q         <= '0;
      par_key_q     <= '0;
      lft_key_q     <= '0;
      rgt_key_q     <= '0;
      par_id_q      <= '0;
      lft_id_q      <= '0;
      rgt_id_q      <= '0;
      st_q          <= StatusOk;
      mkey_q        <= '0;
      mid_q         <= '0;
    end else begin
      unique case (state_q)
        StClear: begin
          clr_q      <= cfg_acc ? '0 : clr_q + slot_t'(1);
          clr_last_q <= !cfg_acc && (clr_q == slot_t'(Capacity - 2));
          state_q    <= cfg_acc ? StClear : state_d;
        end
        StIdle: begin
          state_q <= state_d;
          if (in_acc) begin
            kind_q    <= s_axis_tuser_i;
            qid_q     <= s_axis_tdata_i[SlotW-1:0];
            new_key_q <= s_axis_tdata_i[39:8];
          end
        end
        StLook: begin
          mkey_q <= '0;
          mid_q  <= '0;
          down_q <= 1'b0;
          if (kind_q == KindPop) begin
            if (count_q == '0) begin
              st_q    <= StatusEmpty;
              state_q <= StOut;
            end else begin
              st_q    <= StatusOk;
              cur_q   <= '0;
              state_q <= StPopA;
            end
          end else if ((SlotW+1)'(rd_sl) >= count_q) begin
            st_q    <= StatusNotFound;
            state_q <= StOut;
          end else begin
            st_q      <= StatusOk;
            cur_q     <= rd_sl;
            cur_key_q <= new_key_q;
            cur_id_q  <= qid_q;
            state_q   <= StRead;
          end
        end
        StPopA: state_q <= StPopB;
        StPopB: begin
          mkey_q    <= rd_ka;
          mid_q     <= rd_ia;
          count_q   <= count_q - count_t'(1);
          cur_key_q <= rd_kb;
          cur_id_q  <= rd_ib;
          down_q    <= 1'b1;
          state_q   <= StRead;
        end
        StRead: state_q <= StCmp;
        StCmp: begin
          par_key_q <= rd_ka;  par_id_q <= rd_ia;
          lft_key_q <= rd_ka;  lft_id_q <= rd_ia;
          rgt_key_q <= rd_kb;  rgt_id_q <= rd_ib;
          state_q   <= StSwapA;
        end
        StSwapA: begin
          if (!down_q) begin
            if (cur_q != '0 && cmp.up_swap) cur_q <= par_s;
            else down_q <= 1'b1;
            state_q <= StRead;
          end else if (cmp.go_right) begin
            cur_q <= rgt_s[SlotW-1:0];  state_q <= StRead;
          end else if (cmp.go_left) begin
            cur_q <= lft_s[SlotW-1:0];  state_q <= StRead;
          end else begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      // Output register: loaded once the previous result has left.
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {count_q, mid_q, mkey_q, st_q};
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        if (cfg_index_i == CfgEntryCount) entry_count_q <= cfg_data_i[CountW-1:0];
        else initial_key_q <= cfg_data_i;
      end
      if (state_q == StClear && clr_last_q && !cfg_acc) begin
        count_q <= (entry_count_q > count_t'(Capacity)) ? count_t'(Capacity)
                                                         : entry_count_q;
      end
    end
  end

  // Memory writes: the clearing pass, the pop's hole and the moving entry.
  // The moving entry is written at its slot each step; the displaced
  // neighbor is written at the slot the moving entry leaves.
  always_ff @(posedge clk_i) begin
    if (state_q == StClear) begin
      key_mem[clr_q]  <= initial_key_q;
      id_mem[clr_q]   <= clr_q;
      slot_mem[clr_q] <= clr_q;
    end else if (state_q == StRead) begin
      key_mem[cur_q]     <= cur_key_q;
      id_mem[cur_q]      <= cur_id_q;
      slot_mem[cur_id_q] <= cur_q;
    end else if (state_q == StPopB) begin
      key_mem[last_s] <= rd_ka;
      id_mem[last_s]  <= rd_ia;
      slot_mem[rd_ia] <= last_s;
    end else if (state_q == StSwapA) begin
      if (!down_q) begin
        if (cur_q != '0 && cmp.up_swap) begin
          key_mem[cur_q] <= par_key_q;  id_mem[cur_q] <= par_id_q;
          slot_mem[par_id_q] <= cur_q;
        end
      end else if (cmp.go_right) begin
        key_mem[cur_q] <= rgt_key_q;  id_mem[cur_q] <= rgt_id_q;
        slot_mem[rgt_id_q] <= cur_q;
      end else if (cmp.go_left) begin
        key_mem[cur_q] <= lft_key_q;  id_mem[cur_q] <= lft_id_q;
        slot_mem[lft_id_q] <= cur_q;
      end
    end
  end

  // A held result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_data_q))
    else $error("held result changed");
  // The count never exceeds capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(Capacity)) else $error("heap count overflow");
  // A pop never succeeds on an empty heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPopA) |-> count_q != '0) else $error("pop on empty heap");

endmodule
